[sv/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg - shared types and constants for the line pixel stepper
// Opcode codes, the color width and the default coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    // Default coordinate width in bits
    localparam int COORD_BITS_DEF = 10;

    // Packed 8-bit red, green, blue color
    localparam int COLOR_BITS = 24;

    // Input beat kind, carried on tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

endpackage : lps_pkg

`default_nettype wire

[sv/lps_core.sv]
// ----------------------------------------------------------------------------
// lps_core - line setup and per-pixel stepping
// Holds the line state. A load beat sets up the major axis, lengths and
// directions; a step beat produces the current pixel and advances the state.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_core
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  beat_accept,
    input  wire op_t                   beat_op,
    input  wire logic [COORD_BITS-1:0] x_start,
    input  wire logic [COORD_BITS-1:0] y_start,
    input  wire logic [COORD_BITS-1:0] x_end,
    input  wire logic [COORD_BITS-1:0] y_end,
    output logic                       pix_emit,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic [COORD_BITS-1:0]      pixel_index,
    output logic                       pixel_last
);

    localparam int EW = COORD_BITS + 1;

    logic [COORD_BITS-1:0] cur_major_reg, cur_major_next;
    logic [COORD_BITS-1:0] cur_minor_reg, cur_minor_next;
    logic [COORD_BITS-1:0] major_len_reg, major_len_next;
    logic [COORD_BITS-1:0] minor_len_reg, minor_len_next;
    logic [EW-1:0]         error_acc_reg, error_acc_next;
    logic [COORD_BITS-1:0] steps_done_reg, steps_done_next;
    logic                  x_is_major_reg, x_is_major_next;
    logic                  major_neg_reg, major_neg_next;
    logic                  minor_neg_reg, minor_neg_next;
    logic                  line_active_reg, line_active_next;

    // Setup terms for a load beat
    logic                  x_neg, y_neg, x_major;
    logic [COORD_BITS-1:0] adx, ady;

    // Step terms
    logic [EW-1:0]         acc_sum;
    logic                  minor_adv;
    logic [EW-1:0]         steps_inc;
    logic                  is_last;

    // Absolute differences and major axis choice; a tie goes to y
    always_comb begin
        x_neg   = (x_end < x_start);
        y_neg   = (y_end < y_start);
        adx     = x_neg ? (x_start - x_end) : (x_end - x_start);
        ady     = y_neg ? (y_start - y_end) : (y_end - y_start);
        x_major = (ady < adx);
    end

    // Error term and pixel count for the current step
    always_comb begin
        acc_sum   = error_acc_reg + {1'b0, minor_len_reg};
        minor_adv = (acc_sum >= {1'b0, major_len_reg});
        steps_inc = {1'b0, steps_done_reg} + EW'(1);
        is_last   = (steps_inc >= {1'b0, major_len_reg});
    end

    // Current pixel, shown while a step beat is accepted
    always_comb begin
        pix_emit    = beat_accept && (beat_op == OP_STEP) && line_active_reg;
        pixel_x     = x_is_major_reg ? cur_major_reg : cur_minor_reg;
        pixel_y     = x_is_major_reg ? cur_minor_reg : cur_major_reg;
        pixel_index = steps_done_reg;
        pixel_last  = is_last;
    end

    // Next state: load a new line or advance one pixel
    always_comb begin
        cur_major_next   = cur_major_reg;
        cur_minor_next   = cur_minor_reg;
        major_len_next   = major_len_reg;
        minor_len_next   = minor_len_reg;
        error_acc_next   = error_acc_reg;
        steps_done_next  = steps_done_reg;
        x_is_major_next  = x_is_major_reg;
        major_neg_next   = major_neg_reg;
        minor_neg_next   = minor_neg_reg;
        line_active_next = line_active_reg;
        if (beat_accept && (beat_op == OP_LOAD)) begin
            x_is_major_next = x_major;
            cur_major_next  = x_major ? x_start : y_start;
            cur_minor_next  = x_major ? y_start : x_start;
            major_len_next  = x_major ? adx : ady;
            minor_len_next  = x_major ? ady : adx;
            major_neg_next  = x_major ? x_neg : y_neg;
            minor_neg_next  = x_major ? y_neg : x_neg;
            error_acc_next  = '0;
            steps_done_next = '0;
            line_active_next = ((x_major ? adx : ady) != '0);
        end else if (pix_emit) begin
            cur_major_next = major_neg_reg ? (cur_major_reg - COORD_BITS'(1))
                                           : (cur_major_reg + COORD_BITS'(1));
            if (minor_adv) begin
                error_acc_next = acc_sum - {1'b0, major_len_reg};
                cur_minor_next = minor_neg_reg ? (cur_minor_reg - COORD_BITS'(1))
                                               : (cur_minor_reg + COORD_BITS'(1));
            end else begin
                error_acc_next = acc_sum;
            end
            steps_done_next = steps_inc[COORD_BITS-1:0];
            if (is_last) begin
                line_active_next = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_major_reg   <= '0;
            cur_minor_reg   <= '0;
            major_len_reg   <= '0;
            minor_len_reg   <= '0;
            error_acc_reg   <= '0;
            steps_done_reg  <= '0;
            x_is_major_reg  <= 1'b0;
            major_neg_reg   <= 1'b0;
            minor_neg_reg   <= 1'b0;
            line_active_reg <= 1'b0;
        end else begin
            cur_major_reg   <= cur_major_next;
            cur_minor_reg   <= cur_minor_next;
            major_len_reg   <= major_len_next;
            minor_len_reg   <= minor_len_next;
            error_acc_reg   <= error_acc_next;
            steps_done_reg  <= steps_done_next;
            x_is_major_reg  <= x_is_major_next;
            major_neg_reg   <= major_neg_next;
            minor_neg_reg   <= minor_neg_next;
            line_active_reg <= line_active_next;
        end
    end

`ifndef SYNTH
    // The error term stays below the major length on an active line
    a_err_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |-> (error_acc_reg < {1'b0, major_len_reg}))
        else $error("lps_core: error term out of range");

    // The pixel count never reaches the major length on an active line
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |-> (steps_done_reg < major_len_reg))
        else $error("lps_core: pixel count overran the line");

    // The last pixel ends the line
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_emit && pixel_last) |=> !line_active_reg)
        else $error("lps_core: line still active after last pixel");
`endif

endmodule : lps_core

`default_nettype wire

[sv/lps_out_stage.sv]
// ----------------------------------------------------------------------------
// lps_out_stage - result register on the master stream side
// Holds one pixel beat until the consumer takes it; frees itself in the
// same cycle it is drained so a new pixel can load back to back.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_out_stage
    import lps_pkg::*;
#(
    parameter int DATA_W = 56
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic [DATA_W-1:0] load_data,
    input  wire logic              load_last,
    output logic                   can_load,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;

    // Room when empty or drained this cycle
    always_comb begin
        can_load   = !valid_reg || m_axis_tready;
        valid_next = load ? 1'b1 : (valid_reg && !m_axis_tready);
    end

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
            last_reg <= load_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTH
    // Never load over a pixel that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_axis_tready) |-> !load)
        else $error("lps_out_stage: pending pixel overwritten");

    // A stalled pixel is still offered next cycle
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_axis_tready) |=> valid_reg)
        else $error("lps_out_stage: stalled pixel dropped");

    // A load always shows up as a valid beat
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg)
        else $error("lps_out_stage: loaded pixel not offered");
`endif

endmodule : lps_out_stage

`default_nettype wire

[sv/line_pixel_stepper.sv]
// A step beat's pixel appears on m_axis in the cycle after the beat is accepted.
// Throughput: one input beat and one pixel per cycle while m_axis_tready is high,
// set by the single result register that the stepping logic feeds.
// Load beats and steps with no active line produce no output beat.
// Reset (aresetn low, synchronous) clears the line state, color and output valid flag.
// ----------------------------------------------------------------------------
// line_pixel_stepper - integer line rasterizer, one pixel per step beat on an active line
// Load beats set up a line; step beats emit its pixels with color, index
// and a last flag on tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration: pixel color
    input  wire logic                    cfg_wr_en,
    input  wire logic [COLOR_BITS-1:0]   cfg_wr_data,
    // Input stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata, low bit up: x_start, y_start, x_end, y_end, zero pad
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  wire logic                    s_axis_tuser,
    // Output stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata, low bit up: pixel_x, pixel_y, color, pixel_index, zero pad
    output logic [((3*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                         m_axis_tlast
);

    localparam int IN_W   = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_W  = ((3*COORD_BITS+COLOR_BITS+7)/8)*8;
    localparam int OUT_PAD = OUT_W - (3*COORD_BITS+COLOR_BITS);

    logic [COLOR_BITS-1:0] color_reg;
    logic                  beat_accept;
    logic                  can_load;
    op_t                   beat_op;
    logic                  pix_emit;
    logic [COORD_BITS-1:0] pixel_x, pixel_y, pixel_index;
    logic                  pixel_last;
    logic [OUT_W-1:0]      pix_data;
    logic [IN_W-1:0]       in_data;

    // Color register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '0;
        end else if (cfg_wr_en) begin
            color_reg <= cfg_wr_data;
        end
    end

    // Accept whenever the result register has room
    assign s_axis_tready = can_load;
    assign beat_accept   = s_axis_tvalid && can_load;
    assign beat_op       = op_t'(s_axis_tuser);
    assign in_data       = s_axis_tdata;

    lps_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .beat_op     (beat_op),
        .x_start     (in_data[0*COORD_BITS +: COORD_BITS]),
        .y_start     (in_data[1*COORD_BITS +: COORD_BITS]),
        .x_end       (in_data[2*COORD_BITS +: COORD_BITS]),
        .y_end       (in_data[3*COORD_BITS +: COORD_BITS]),
        .pix_emit    (pix_emit),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_index (pixel_index),
        .pixel_last  (pixel_last)
    );

    // Pack the pixel beat
    generate
        if (OUT_PAD > 0) begin : g_pad
            assign pix_data = {{OUT_PAD{1'b0}}, pixel_index, color_reg, pixel_y, pixel_x};
        end else begin : g_nopad
            assign pix_data = {pixel_index, color_reg, pixel_y, pixel_x};
        end
    endgenerate

    lps_out_stage #(
        .DATA_W (OUT_W)
    ) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (pix_emit),
        .load_data     (pix_data),
        .load_last     (pixel_last),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule : line_pixel_stepper

`default_nettype wire
